// ===== rtl/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg: shared definitions for the sphere and box collision test
// Shape and operation codes, the pair classification and the queued job width.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int COORD_BITS_DEF = 24;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  localparam logic [1:0] SHAPE_SPHERE = 2'd0;
  localparam logic [1:0] SHAPE_BOX    = 2'd1;

  // Pair classification made by the front end. In a sphere/box pair the
  // sphere is always placed in collider A.
  typedef enum logic [1:0] {
    KIND_SS    = 2'd0,
    KIND_SB    = 2'd1,
    KIND_BB    = 2'd2,
    KIND_UNSUP = 2'd3
  } kind_t;

  // Job layout: kind, A centers, A extents, B centers, B extents.
  function automatic int job_bits(input int cw);
    return 2 + 2 * (3 * cw + 3 * (cw - 1));
  endfunction

endpackage

// ===== rtl/sbc_front.sv =====
// ----------------------------------------------------------------------------
// sbc_front: item intake and pair classification
// Holds the first collider and turns each test item that finds one stored into a queued job.
// ----------------------------------------------------------------------------
module sbc_front import sbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic                         op,
  input  logic [1:0]                   shape,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic signed [COORD_BITS-1:0] center_z,
  input  logic [COORD_BITS-2:0]        extent_x,
  input  logic [COORD_BITS-2:0]        extent_y,
  input  logic [COORD_BITS-2:0]        extent_z,
  output logic                         job_valid,
  input  logic                         job_ready,
  output logic [job_bits(COORD_BITS)-1:0] job
);

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS - 1;

  logic                 first_loaded;
  logic [1:0]           first_shape;
  logic signed [CW-1:0] first_cx, first_cy, first_cz;
  logic [EW-1:0]        first_ex, first_ey, first_ez;

  logic  accept;
  logic  first_ok, cur_ok, swap;
  kind_t kind;

  assign item_ready = job_ready;
  assign accept     = item_valid && item_ready;
  assign job_valid  = item_valid && (op == OP_TEST) && first_loaded;

  assign first_ok = (first_shape == SHAPE_SPHERE) || (first_shape == SHAPE_BOX);
  assign cur_ok   = (shape == SHAPE_SPHERE) || (shape == SHAPE_BOX);
  // A box stored first against a sphere now: swap so the sphere sits in A.
  assign swap     = (first_shape == SHAPE_BOX) && (shape == SHAPE_SPHERE);

  always_comb begin
    if (!first_ok || !cur_ok) begin
      kind = KIND_UNSUP;
    end else if (first_shape == SHAPE_SPHERE && shape == SHAPE_SPHERE) begin
      kind = KIND_SS;
    end else if (first_shape == SHAPE_BOX && shape == SHAPE_BOX) begin
      kind = KIND_BB;
    end else begin
      kind = KIND_SB;
    end
  end

  always_comb begin
    if (swap) begin
      job = {kind, center_z, center_y, center_x, extent_z, extent_y, extent_x,
             first_cz, first_cy, first_cx, first_ez, first_ey, first_ex};
    end else begin
      job = {kind, first_cz, first_cy, first_cx, first_ez, first_ey, first_ex,
             center_z, center_y, center_x, extent_z, extent_y, extent_x};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_loaded <= 1'b0;
      first_shape  <= SHAPE_SPHERE;
    end else if (accept) begin
      if (op == OP_STORE) begin
        first_loaded <= 1'b1;
        first_shape  <= shape;
      end else begin
        first_loaded <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_STORE) begin
      first_cx <= center_x;
      first_cy <= center_y;
      first_cz <= center_z;
      first_ex <= extent_x;
      first_ey <= extent_y;
      first_ez <= extent_z;
    end
  end

endmodule

// ===== rtl/sbc_queue.sv =====
// ----------------------------------------------------------------------------
// sbc_queue: two-entry job queue
// Decouples the front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module sbc_queue import sbc_pkg::*; #(
  parameter int WIDTH = job_bits(COORD_BITS_DEF)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/sbc_back.sv =====
// ----------------------------------------------------------------------------
// sbc_back: overlap arithmetic pipeline
// Gaps and radii, then squares, then the sum and compare into the result.
// ----------------------------------------------------------------------------
module sbc_back import sbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            job_valid,
  output logic                            job_ready,
  input  logic [job_bits(COORD_BITS)-1:0] job,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic                            hit,
  output logic                            unsupported
);

  localparam int CW = COORD_BITS;
  localparam int EW = COORD_BITS - 1;
  localparam int SW = COORD_BITS + 2;  // signed working width for gaps
  localparam int MW = COORD_BITS + 1;  // magnitude width
  localparam int QW = 2 * MW;          // square width
  localparam int TW = QW + 2;          // sum of three squares

  logic [1:0]           kind_bits;
  kind_t                kind;
  logic signed [CW-1:0] a_c [3];
  logic signed [CW-1:0] b_c [3];
  logic [EW-1:0]        a_e [3];
  logic [EW-1:0]        b_e [3];

  assign {kind_bits, a_c[2], a_c[1], a_c[0], a_e[2], a_e[1], a_e[0],
          b_c[2], b_c[1], b_c[0], b_e[2], b_e[1], b_e[0]} = job;
  assign kind = kind_t'(kind_bits);

  logic          en;
  logic [MW-1:0] mag [3];
  logic [MW-1:0] rad;
  logic [2:0]    ovl;

  assign en        = !result_valid || result_ready;
  assign job_ready = en;

  always_comb begin
    logic signed [SW-1:0] ac, bc, ae, be, lo, hi, d;
    for (int i = 0; i < 3; i++) begin
      ac = SW'(a_c[i]);
      bc = SW'(b_c[i]);
      // Extents are held in signed working variables so that every sum and
      // compare below stays signed.
      ae = SW'({1'b0, a_e[i]});
      be = SW'({1'b0, b_e[i]});
      lo = bc - be;
      hi = bc + be;
      if (kind == KIND_SS) begin
        d = (ac >= bc) ? (ac - bc) : (bc - ac);
      end else if (ac < lo) begin
        d = lo - ac;
      end else if (ac > hi) begin
        d = ac - hi;
      end else begin
        d = '0;
      end
      mag[i] = d[MW-1:0];
      // Closed interval test for two boxes on this axis.
      ovl[i] = !((ac + ae < lo) || (ac - ae > hi));
    end
  end

  assign rad = (kind == KIND_SS) ? (MW'(a_e[0]) + MW'(b_e[0])) : MW'(a_e[0]);

  // Stage 1: gaps and radius.
  logic          v1;
  kind_t         kind1;
  logic [MW-1:0] mag1 [3];
  logic [MW-1:0] rad1;
  logic          bb1;

  // Stage 2: squares.
  logic          v2;
  kind_t         kind2;
  logic [QW-1:0] sq2 [3];
  logic [QW-1:0] rsq2;
  logic          bb2;

  logic [TW-1:0] dist_sq;
  assign dist_sq = TW'(sq2[0]) + TW'(sq2[1]) + TW'(sq2[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1           <= job_valid;
      v2           <= v1;
      result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind1 <= kind;
      rad1  <= rad;
      bb1   <= &ovl;
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= mag[i];
        sq2[i]  <= QW'(mag1[i]) * QW'(mag1[i]);
      end
      kind2 <= kind1;
      rsq2  <= QW'(rad1) * QW'(rad1);
      bb2   <= bb1;
      unsupported <= (kind2 == KIND_UNSUP);
      case (kind2)
        KIND_SS, KIND_SB: hit <= (dist_sq <= TW'(rsq2));
        KIND_BB:          hit <= bb2;
        default:          hit <= 1'b0;
      endcase
    end
  end

endmodule

// ===== rtl/sphere_box_collision_test.sv =====
// ----------------------------------------------------------------------------
// sphere_box_collision_test: overlap test for sphere and box collider pairs
// Throughput: one item per cycle; the four-stage path (queue, gaps, squares,
// sum and compare) is fully pipelined and stalls only on the result side.
// Reset clears the stored-collider flag, the queue and all valid bits; the
// stored collider payload itself is not reset.
// ----------------------------------------------------------------------------
// Each pair arrives as two items. A store item (op 0) records the first
// collider, replacing any earlier one. A test item (op 1) pairs the current
// collider with the stored one and yields one result; a test item with
// nothing stored is taken and dropped. Coordinates are signed fixed point,
// extents unsigned, all with the same binary point, and every comparison is
// exact.
//
// The front end classifies the pair (sphere/sphere, sphere/box with the
// sphere moved into the first slot, box/box or unsupported) and pushes a job
// into a two-entry queue. The back end computes per-axis gaps, squares them
// with four parallel multipliers, and registers the final compare in the
// output register, which holds a result until its transfer completes.
// ----------------------------------------------------------------------------
module sphere_box_collision_test import sbc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic                         op,
  input  logic [1:0]                   shape,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic signed [COORD_BITS-1:0] center_z,
  input  logic [COORD_BITS-2:0]        extent_x,
  input  logic [COORD_BITS-2:0]        extent_y,
  input  logic [COORD_BITS-2:0]        extent_z,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic                         hit,
  output logic                         unsupported
);

  localparam int JW = job_bits(COORD_BITS);

  // Front end to queue.
  logic          push_valid, push_ready;
  logic [JW-1:0] push_data;

  // Queue to back end.
  logic          pop_valid, pop_ready;
  logic [JW-1:0] pop_data;

  sbc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .op         (op),
    .shape      (shape),
    .center_x   (center_x),
    .center_y   (center_y),
    .center_z   (center_z),
    .extent_x   (extent_x),
    .extent_y   (extent_y),
    .extent_z   (extent_z),
    .job_valid  (push_valid),
    .job_ready  (push_ready),
    .job        (push_data)
  );

  // The queue lets the front end keep taking items for a short while when
  // the result side stalls.
  sbc_queue #(
    .WIDTH (JW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sbc_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (pop_valid),
    .job_ready    (pop_ready),
    .job          (pop_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .hit          (hit),
    .unsupported  (unsupported)
  );

endmodule

// ===== rtl/sbc_checker.sv =====
// ----------------------------------------------------------------------------
// sbc_checker: port-level checks for the collision test
// Watches the top-level ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
module sbc_checker (
  input logic clk,
  input logic rst,
  input logic item_ready,
  input logic result_valid,
  input logic result_ready,
  input logic hit,
  input logic unsupported
);

  // An unsupported pair never reports a hit.
  a_unsup_no_hit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(unsupported && hit))
    else $error("unsupported result reported a hit");

  // Reset empties the pipeline.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // Reset empties the queue, so the block takes items right away.
  a_reset_ready: assert property (@(posedge clk)
    $past(rst) |-> item_ready)
    else $error("not ready after reset");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(hit) && $stable(unsupported))
    else $error("stalled result changed");

endmodule

bind sphere_box_collision_test sbc_checker u_sbc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .hit          (hit),
  .unsupported  (unsupported)
);
